[rtl/clr_pkg.sv]
// ----------------------------------------------------------------------------
// clr_pkg: shared types for the clipped line rasterizer
// Opcodes, draw kinds and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package clr_pkg;
  typedef enum logic {OP_LOAD = 1'b0, OP_STEP = 1'b1} opcode_e;
  typedef enum logic [1:0] {KIND_AXIS = 2'd0, KIND_DDA = 2'd1, KIND_BRES = 2'd2} kind_e;
  typedef enum logic [2:0] {
    REG_USE_DDA = 3'd0, REG_CLIP_XL = 3'd1, REG_CLIP_YL = 3'd2, REG_CLIP_XH = 3'd3,
    REG_CLIP_YH = 3'd4, REG_WIN_W = 3'd5, REG_WIN_H = 3'd6
  } reg_e;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgDataBits = 32;
  localparam int unsigned RstClipHigh = 999;
  localparam int unsigned RstWindow = 300;
endpackage
`default_nettype wire

[rtl/clr_if.sv]
// ----------------------------------------------------------------------------
// clr_if: valid/ready channel interfaces
// Item, pixel and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none
interface clr_item_if #(parameter int CB = 10);
  logic valid;
  logic ready;
  logic opcode;
  logic [CB-1:0] start_x, start_y, end_x, end_y;
  modport source (output valid, opcode, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, opcode, start_x, start_y, end_x, end_y, output ready);
endinterface

interface clr_pixel_if #(parameter int CB = 10);
  logic valid;
  logic ready;
  logic [CB-1:0] pixel_x, pixel_y;
  logic [2*CB-1:0] pixel_index;
  logic inside_clip, last_pixel;
  modport source (output valid, pixel_x, pixel_y, pixel_index, inside_clip, last_pixel,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_index, inside_clip, last_pixel,
                output ready);
endinterface

interface clr_cfg_if;
  logic valid;
  logic ready;
  logic [clr_pkg::CfgIdxBits-1:0] index;
  logic [clr_pkg::CfgDataBits-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/clr_front.sv]
// ----------------------------------------------------------------------------
// clr_front: input queue
// Two-entry FIFO that takes item transactions and hands them to the engine.
// ----------------------------------------------------------------------------
`default_nettype none
module clr_front #(
  parameter int CB = 10
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [4*CB:0] in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [4*CB:0]      out_data_o
);
  logic [4*CB:0] mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic wr_q, rd_q;
  logic push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;
  assign out_data_o = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q <= 1'b0;
      rd_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_data_i;
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("fifo overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !push) else $error("push while full");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1)) else $error("count slip");
endmodule
`default_nettype wire

[rtl/clr_divider.sv]
// ----------------------------------------------------------------------------
// clr_divider: restoring divider
// One quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
`default_nettype none
module clr_divider #(
  parameter int NB = 27,
  parameter int DB = 11
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NB-1:0] num_i,
  input  wire logic [DB:0]   den_i,
  output logic               busy_o,
  output logic [NB-1:0]      quot_o
);
  localparam int CntBits = $clog2(NB + 1);
  logic [NB-1:0] quo_q;
  logic [DB:0] den_q;
  logic [DB+1:0] rem_q, trial;
  logic [CntBits-1:0] cnt_q;

  assign busy_o = (cnt_q != '0);
  assign quot_o = quo_q;
  assign trial = {rem_q[DB:0], quo_q[NB-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntBits'(NB);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_o) begin
      if (trial >= {1'b0, den_q}) begin
        rem_q <= trial - {1'b0, den_q};
        quo_q <= {quo_q[NB-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[NB-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

[rtl/clr_engine.sv]
// ----------------------------------------------------------------------------
// clr_engine: line setup and pixel stepping
// Loads lines, runs the DDA slope divide, steps pixels into an output register.
// ----------------------------------------------------------------------------
`default_nettype none
module clr_engine #(
  parameter int CB = 10,
  parameter int FB = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [4*CB:0] in_data_i,
  input  wire logic          use_dda_i,
  input  wire logic [CB-1:0] xlo_i, ylo_i, xhi_i, yhi_i, ww_i, wh_i,
  clr_pixel_if.source        pix
);
  localparam int SB = CB + 1;          // sign-bit index of signed coordinates (width SB+1)
  localparam int NB = CB + FB + 1;     // divider numerator width
  localparam int QB = CB + FB + 2;     // signed slope width
  localparam int PB = QB + CB + 2;     // product width
  localparam int EB = CB + 4;          // error term width

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001, ST_DIV = 4'b0010, ST_MUL = 4'b0100, ST_EMIT = 4'b1000
  } state_e;

  state_e state_q;
  logic active_q, ymaj_q, mdir_q, dda_neg_q;
  clr_pkg::kind_e kind_q;
  logic signed [SB:0] cur_a_q, cur_b_q, org_a_q, org_b_q, end_a_q, end_b_q;
  logic signed [SB:0] dma_q, dmi_q;
  logic signed [EB-1:0] err_q;
  logic signed [QB-1:0] slope_q;
  logic signed [PB-1:0] prod_q;
  logic div_start;
  logic div_busy;
  logic [NB-1:0] div_q;

  // pixel output register
  logic ov_q;
  logic [CB-1:0] ox_q, oy_q;
  logic [2*CB-1:0] oidx_q;
  logic oin_q, olast_q;

  // live limits
  logic signed [SB:0] xlo, ylo, xhi, yhi, alo, ahi, blo, bhi;
  always_comb begin
    xlo = (SB+1)'(xlo_i);
    ylo = (SB+1)'(ylo_i);
    xhi = (ww_i < xhi_i) ? (SB+1)'(ww_i) : (SB+1)'(xhi_i);
    yhi = (wh_i < yhi_i) ? (SB+1)'(wh_i) : (SB+1)'(yhi_i);
    alo = ymaj_q ? ylo : xlo;
    ahi = ymaj_q ? yhi : xhi;
    blo = ymaj_q ? xlo : ylo;
    bhi = ymaj_q ? xhi : yhi;
  end

  // load decode
  logic op;
  logic signed [SB:0] x1, y1, x2, y2, dx, dy, adx, ady;
  logic l_ymaj;
  clr_pkg::kind_e l_kind;
  logic signed [SB:0] a1, b1, a2, b2, oa, ob, ea, eb, ldma, ldmi, lstart;
  logic lmdir;
  always_comb begin
    op = in_data_i[4*CB];
    x1 = (SB+1)'(in_data_i[4*CB-1 -: CB]);
    y1 = (SB+1)'(in_data_i[3*CB-1 -: CB]);
    x2 = (SB+1)'(in_data_i[2*CB-1 -: CB]);
    y2 = (SB+1)'(in_data_i[CB-1:0]);
    dx = x2 - x1;
    dy = y2 - y1;
    adx = dx[SB] ? -dx : dx;
    ady = dy[SB] ? -dy : dy;
    if (dx == 0 || dy == 0) begin
      l_kind = clr_pkg::KIND_AXIS;
      l_ymaj = (dx == 0);
    end else if (use_dda_i) begin
      l_kind = clr_pkg::KIND_DDA;
      l_ymaj = ady > adx;
    end else begin
      l_kind = clr_pkg::KIND_BRES;
      l_ymaj = !(ady < adx);
    end
    a1 = l_ymaj ? y1 : x1;
    b1 = l_ymaj ? x1 : y1;
    a2 = l_ymaj ? y2 : x2;
    b2 = l_ymaj ? x2 : y2;
    if (a1 > a2) begin
      oa = a2; ob = b2; ea = a1; eb = b1;
    end else begin
      oa = a1; ob = b1; ea = a2; eb = b2;
    end
    ldma = ea - oa;
    ldmi = (eb < ob) ? ob - eb : eb - ob;
    lmdir = eb < ob;
    lstart = oa;
  end

  // load-time limits use the new major orientation
  logic signed [SB:0] lalo, lahi, lblo, lbhi, lst;
  logic lact;
  always_comb begin
    lalo = l_ymaj ? ylo : xlo;
    lahi = l_ymaj ? yhi : xhi;
    lblo = l_ymaj ? xlo : ylo;
    lbhi = l_ymaj ? xhi : yhi;
    lst = (l_kind == clr_pkg::KIND_BRES) ? lstart : ((lstart > lalo) ? lstart : lalo);
    lact = !(lst > ((lahi < ea) ? lahi : ea));
    if (l_kind == clr_pkg::KIND_AXIS && !(ob > lblo && ob < lbhi)) lact = 1'b0;
    if (l_kind == clr_pkg::KIND_BRES) begin
      if (lmdir) lact = lact && (ob >= ((eb > lblo) ? eb : lblo));
      else lact = lact && (ob <= ((eb < lbhi) ? eb : lbhi));
    end
  end

  // step datapath
  logic signed [SB:0] mnr, nmaj, nmin, rmin, px, py;
  logic signed [PB-1:0] rnd_abs, rv;
  logic in_clip, up, nact;
  logic signed [EB-1:0] nerr;
  logic [2*CB-1:0] idx;
  always_comb begin
    rv = prod_q;
    rnd_abs = (rv[PB-1] ? -rv : rv) + (PB'(1) <<< (FB - 1));
    rnd_abs = rnd_abs >>> FB;
    rmin = (SB+1)'(rv[PB-1] ? -rnd_abs : rnd_abs);
    if (!ymaj_q) rmin = rmin + org_b_q;
    if (kind_q == clr_pkg::KIND_BRES) mnr = cur_b_q;
    else if (kind_q == clr_pkg::KIND_AXIS) mnr = org_b_q;
    else mnr = rmin;
    if (kind_q == clr_pkg::KIND_AXIS) in_clip = 1'b1;
    else if (kind_q == clr_pkg::KIND_DDA) in_clip = (mnr >= blo) && (mnr <= bhi);
    else if (mdir_q) in_clip = (cur_a_q >= alo) && (mnr <= ((bhi < org_b_q) ? bhi : org_b_q));
    else in_clip = (cur_a_q >= alo) && (mnr >= ((blo > org_b_q) ? blo : org_b_q));
    px = ymaj_q ? mnr : cur_a_q;
    py = ymaj_q ? cur_a_q : mnr;
    idx = (2*CB)'(py[CB-1:0] * ww_i) + (2*CB)'(px[CB-1:0]);
    up = (ymaj_q && !mdir_q) ? (err_q >= 0) : (err_q > 0);
    nmin = org_b_q;
    nerr = err_q;
    if (kind_q == clr_pkg::KIND_BRES) begin
      if (up) begin
        nmin = cur_b_q + (mdir_q ? -(SB+1)'(1) : (SB+1)'(1));
        nerr = err_q + EB'(2 * dmi_q) - EB'(2 * dma_q);
      end else begin
        nmin = cur_b_q;
        nerr = err_q + EB'(2 * dmi_q);
      end
    end
    nmaj = cur_a_q + 1'b1;
    nact = !(nmaj > ((ahi < end_a_q) ? ahi : end_a_q));
    if (kind_q == clr_pkg::KIND_BRES) begin
      if (mdir_q) nact = nact && (nmin >= ((end_b_q > blo) ? end_b_q : blo));
      else nact = nact && (nmin <= ((end_b_q < bhi) ? end_b_q : bhi));
    end
  end

  logic take;
  assign in_ready_o = (state_q == ST_IDLE) && !ov_q;
  assign take = in_valid_i && in_ready_o;
  assign div_start = take && op == clr_pkg::OP_LOAD && l_kind == clr_pkg::KIND_DDA;

  clr_divider #(.NB(NB), .DB(SB)) u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .num_i((NB'(ldmi) << (FB + 1)) + NB'(ldma)),
    .den_i((SB+1)'(ldma <<< 1)),
    .busy_o(div_busy), .quot_o(div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      active_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (ov_q && pix.ready) ov_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (take && op == clr_pkg::OP_LOAD) begin
            active_q <= lact;
            if (l_kind == clr_pkg::KIND_DDA) state_q <= ST_DIV;
            else if (lact && l_kind == clr_pkg::KIND_AXIS) state_q <= ST_MUL;
          end else if (take && active_q) begin
            state_q <= ST_EMIT;
          end
        end
        ST_DIV: if (!div_start && !div_busy) state_q <= ST_MUL;
        ST_MUL: state_q <= ST_IDLE;
        ST_EMIT: begin
          ov_q <= 1'b1;
          active_q <= nact;
          state_q <= (kind_q == clr_pkg::KIND_BRES) ? ST_IDLE : ST_MUL;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && op == clr_pkg::OP_LOAD) begin
      kind_q <= l_kind;
      ymaj_q <= l_ymaj;
      org_a_q <= oa;
      org_b_q <= ob;
      end_a_q <= ea;
      end_b_q <= eb;
      dma_q <= ldma;
      dmi_q <= ldmi;
      mdir_q <= lmdir;
      cur_a_q <= lst;
      cur_b_q <= ob;
      err_q <= EB'(2 * ldmi) - EB'(ldma);
      slope_q <= '0;
      dda_neg_q <= ((l_ymaj ? dx : dy) < 0) != ((l_ymaj ? dy : dx) < 0);
    end
    if (state_q == ST_DIV && !div_start && !div_busy)
      slope_q <= dda_neg_q ? -QB'(div_q) : QB'(div_q);
    if (state_q == ST_MUL)
      prod_q <= slope_q * PB'(cur_a_q - org_a_q) +
                (ymaj_q ? (PB'(org_b_q) <<< FB) : PB'(0));
    if (state_q == ST_EMIT) begin
      ox_q <= px[CB-1:0];
      oy_q <= py[CB-1:0];
      oidx_q <= idx;
      oin_q <= in_clip;
      olast_q <= !nact;
      cur_a_q <= nmaj;
      cur_b_q <= nmin;
      err_q <= nerr;
    end
  end

  assign pix.valid = ov_q;
  assign pix.pixel_x = ox_q;
  assign pix.pixel_y = oy_q;
  assign pix.pixel_index = oidx_q;
  assign pix.inside_clip = oin_q;
  assign pix.last_pixel = olast_q;

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> !ov_q) else $error("pixel overwritten");
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |=> ov_q) else $error("pixel not posted");
endmodule
`default_nettype wire

[rtl/clipped_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// clipped_line_rasterizer: top level
// Clipped line rasterizer with Bresenham or DDA stepping; axis-aligned lines use their own path.
// ----------------------------------------------------------------------------
// Path: a step transaction's pixel passes the queue, the engine's ST_EMIT state
//   and the pixel register before it is offered, for every draw kind.
// Flow: the engine takes no new item until the pixel register has drained;
//   loads pass no state (Bresenham), ST_MUL (axis) or ST_DIV and ST_MUL (DDA).
// Reset: rst_ni is asynchronous, active low; clears the queue, line state and
//   configuration to defaults (clip highs 999, window 300 by 300).
`default_nettype none
module clipped_line_rasterizer #(
  parameter int COORD_BITS = 10,
  parameter int SLOPE_FRAC_BITS = 16
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  clr_item_if.sink in,
  clr_pixel_if.source out,
  clr_cfg_if.sink cfg
);
  localparam int CB = COORD_BITS;

  // configuration registers, always writable
  logic use_dda_q;
  logic [CB-1:0] xlo_q, ylo_q, xhi_q, yhi_q, ww_q, wh_q;
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_dda_q <= 1'b0;
      xlo_q <= '0;
      ylo_q <= '0;
      xhi_q <= CB'(clr_pkg::RstClipHigh);
      yhi_q <= CB'(clr_pkg::RstClipHigh);
      ww_q <= CB'(clr_pkg::RstWindow);
      wh_q <= CB'(clr_pkg::RstWindow);
    end else if (cfg.valid) begin
      case (clr_pkg::reg_e'(cfg.index))
        clr_pkg::REG_USE_DDA: use_dda_q <= cfg.data[0];
        clr_pkg::REG_CLIP_XL: xlo_q <= cfg.data[CB-1:0];
        clr_pkg::REG_CLIP_YL: ylo_q <= cfg.data[CB-1:0];
        clr_pkg::REG_CLIP_XH: xhi_q <= cfg.data[CB-1:0];
        clr_pkg::REG_CLIP_YH: yhi_q <= cfg.data[CB-1:0];
        clr_pkg::REG_WIN_W: ww_q <= cfg.data[CB-1:0];
        clr_pkg::REG_WIN_H: wh_q <= cfg.data[CB-1:0];
        default: ;
      endcase
    end
  end

  // front: transaction queue decouples the input from the engine
  logic q_valid, q_ready;
  logic [4*CB:0] q_data;
  clr_front #(.CB(CB)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in.valid), .in_ready_o(in.ready),
    .in_data_i({in.opcode, in.start_x, in.start_y, in.end_x, in.end_y}),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_data_o(q_data)
  );

  // back: setup, divide, stepping, pixel register
  clr_engine #(.CB(CB), .FB(SLOPE_FRAC_BITS)) u_engine (
    .clk_i, .rst_ni,
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_data_i(q_data),
    .use_dda_i(use_dda_q), .xlo_i(xlo_q), .ylo_i(ylo_q), .xhi_i(xhi_q),
    .yhi_i(yhi_q), .ww_i(ww_q), .wh_i(wh_q),
    .pix(out)
  );
endmodule
`default_nettype wire
